/* rtl/average_reward_td_update_unit_assert.svh */
// Assertion macros for the average-reward TD update unit
`ifndef AVERAGE_REWARD_TD_UPDATE_UNIT_ASSERT_SVH
`define AVERAGE_REWARD_TD_UPDATE_UNIT_ASSERT_SVH

// implication checked on every clock edge out of reset
`define ARTD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("artd check failed");

// next-cycle implication checked on every clock edge out of reset
`define ARTD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("artd check failed");

`endif

/* rtl/artd_pkg.sv */
// Package: sizes, kind codes, saturating helpers for the TD update unit
`default_nettype none
package artd_pkg;
	localparam int NUM_STATES  = 256;
	localparam int NUM_ACTIONS = 8;
	localparam int VALUE_BITS  = 32;
	localparam int ST_W  = $clog2(NUM_STATES);
	localparam int ACT_W = $clog2(NUM_ACTIONS);
	localparam int ADDR_W = ST_W + ACT_W;
	localparam int DEPTH = NUM_STATES * NUM_ACTIONS;
	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 1;

	typedef logic signed [VALUE_BITS-1:0] val_t;

	typedef enum logic [1:0] {
		KIND_START = 2'd0,
		KIND_STEP  = 2'd1,
		KIND_END   = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	localparam logic [CFG_IDX_W-1:0] REG_VALUE_RATE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_AVG_RATE   = 1'b1;

	localparam val_t VMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
	localparam val_t VMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

	// saturate a one-bit-wider result to the value range
	function automatic val_t sat(input logic signed [VALUE_BITS:0] x);
		if (x[VALUE_BITS] != x[VALUE_BITS-1]) begin
			return x[VALUE_BITS] ? VMIN : VMAX;
		end
		return x[VALUE_BITS-1:0];
	endfunction
endpackage
`default_nettype wire

/* rtl/average_reward_td_update_unit.sv */
// Average-reward TD (R-learning) update unit: sequencer, value memory, shared ALU
// Time from accept to result strobe grows by kind (start or unused, then end, then step)
// and grows further when the mean reward is updated; it is set by the single memory read
// port and the one shared add/multiply unit. busy drops as the strobe rises, so a request
// is taken only after the last one is through; results cannot be stalled. After reset a
// clearing pass zeroes all 2048 entries of the value memory; busy is high then.
`default_nettype none
module average_reward_td_update_unit (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                start,
	output logic                               busy,
	input  wire  [1:0]                         kind,
	input  wire  signed [31:0]                 reward,
	input  wire  [7:0]                         next_state,
	input  wire  [2:0]                         next_action,
	input  wire                                cfg_we,
	input  wire  [artd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire  [artd_pkg::CFG_W-1:0]         cfg_data,
	output logic                               done,
	output logic signed [31:0]                 updated_value,
	output logic signed [31:0]                 mean_reward,
	output logic                               mean_updated,
	output logic [2:0]                         greedy_action,
	output logic signed [31:0]                 greedy_value
);
	import artd_pkg::*;
`include "average_reward_td_update_unit_assert.svh"

	typedef enum logic [10:0] {
		S_CLEAR = 11'b00000000001,
		S_IDLE  = 11'b00000000010,
		S_SCANN = 11'b00000000100,
		S_RDCUR = 11'b00000001000,
		S_D1    = 11'b00000010000,
		S_MUL1  = 11'b00000100000,
		S_WR    = 11'b00001000000,
		S_SCANC = 11'b00010000000,
		S_MUL2  = 11'b00100000000,
		S_SCANR = 11'b01000000000,
		S_OUT   = 11'b10000000000
	} state_t;

	state_t state_q;
	logic [ADDR_W-1:0] clr_q;
	logic [CFG_W-1:0] vrate_q, arate_q;
	val_t avg_q;
	logic [ST_W-1:0] cur_s_q, rep_s_q;
	logic [ACT_W-1:0] cur_a_q;
	kind_t kind_q;
	val_t r_q;
	logic [ST_W-1:0] ns_q;
	logic [ACT_W-1:0] na_q;

	// memory
	val_t mem [DEPTH];
	logic [ADDR_W-1:0] raddr;
	val_t rdata_q;
	logic mem_we;
	logic [ADDR_W-1:0] waddr;
	val_t wdata;

	// scan control: issue counter, valid of data in flight
	logic [ACT_W:0] iss_q;
	logic           rv_q;
	logic [ACT_W-1:0] ra_q;
	val_t mx_q;
	logic [ACT_W-1:0] marg_q;
	logic           mfirst_q;
	logic [ST_W-1:0] scan_s;

	val_t mxn_q, upd_q, d_q;
	logic [2:0] sub_q;
	logic signed [VALUE_BITS+CFG_W:0] prod_q;
	logic pv_q, mupd_q;

	// shared ALU: saturating add with optional negation
	val_t alu_a, alu_b;
	logic alu_sub;
	val_t alu_y;
	always_comb begin
		alu_y = alu_sub ? sat(VALUE_BITS'(0) + {alu_a[VALUE_BITS-1], alu_a} -
			{alu_b[VALUE_BITS-1], alu_b})
			: sat({alu_a[VALUE_BITS-1], alu_a} + {alu_b[VALUE_BITS-1], alu_b});
	end

	// product floor(rate*d/65536) fits the value range
	logic [CFG_W-1:0] mrate;
	val_t prod_v;
	assign prod_v = val_t'(prod_q >>> CFG_W);

	assign busy = (state_q != S_IDLE);
	assign scan_s = (state_q == S_SCANN) ? ns_q : (state_q == S_SCANC) ? cur_s_q : rep_s_q;
	logic scanning;
	assign scanning = (state_q == S_SCANN) || (state_q == S_SCANC) || (state_q == S_SCANR);
	logic scan_last;
	assign scan_last = rv_q && (ra_q == ACT_W'(NUM_ACTIONS-1));

	always_comb begin
		raddr = {scan_s, iss_q[ACT_W-1:0]};
		// current pair stays addressed while its value is used
		if (state_q == S_RDCUR || state_q == S_D1) raddr = {cur_s_q, cur_a_q};
		mem_we = 1'b0;
		waddr = {cur_s_q, cur_a_q};
		wdata = upd_q;
		if (state_q == S_CLEAR) begin
			mem_we = 1'b1;
			waddr = clr_q;
			wdata = '0;
		end else if (state_q == S_WR) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	// ALU operand selection by step
	always_comb begin
		alu_a = r_q;
		alu_b = avg_q;
		alu_sub = 1'b1;
		mrate = vrate_q;
		if (state_q == S_D1) begin
			unique case (sub_q)
				3'd0: begin alu_a = r_q; alu_b = avg_q; alu_sub = 1'b1; end
				3'd1: begin alu_a = d_q; alu_b = mxn_q; alu_sub = 1'b0; end
				default: begin alu_a = d_q; alu_b = rdata_q; alu_sub = 1'b1; end
			endcase
		end else if (state_q == S_MUL1) begin
			alu_a = upd_q; alu_b = prod_v; alu_sub = 1'b0;
		end else if (state_q == S_MUL2) begin
			mrate = arate_q;
			case (sub_q)
				3'd0: begin alu_a = r_q; alu_b = avg_q; alu_sub = 1'b1; end
				3'd1: begin alu_a = d_q; alu_b = mxn_q; alu_sub = 1'b0; end
				3'd2: begin alu_a = d_q; alu_b = mx_q; alu_sub = 1'b1; end
				default: begin alu_a = avg_q; alu_b = prod_v; alu_sub = 1'b0; end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			vrate_q <= CFG_W'(6554);
			arate_q <= CFG_W'(655);
			avg_q <= '0;
			cur_s_q <= '0;
			cur_a_q <= '0;
			rep_s_q <= '0;
			kind_q <= KIND_START;
			iss_q <= '0;
			rv_q <= 1'b0;
			sub_q <= '0;
			pv_q <= 1'b0;
			mupd_q <= 1'b0;
			done <= 1'b0;
		end else begin
			done <= (state_q == S_OUT);
			if (cfg_we) begin
				if (cfg_index == REG_VALUE_RATE) vrate_q <= cfg_data;
				if (cfg_index == REG_AVG_RATE) arate_q <= cfg_data;
			end
			// row scan pipeline: issue a read per cycle, compare the returned entry
			if (scanning) begin
				if (scan_last) begin
					iss_q <= '0;
					rv_q <= 1'b0;
					mfirst_q <= 1'b1;
				end else begin
					if (!iss_q[ACT_W]) iss_q <= iss_q + 1'b1;
					rv_q <= !iss_q[ACT_W];
					ra_q <= iss_q[ACT_W-1:0];
					if (rv_q) mfirst_q <= 1'b0;
				end
				if (rv_q && (mfirst_q || rdata_q > mx_q)) begin
					mx_q <= rdata_q;
					marg_q <= ra_q;
				end
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(DEPTH-1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) begin
						kind_q <= kind_t'(kind);
						r_q <= reward;
						ns_q <= next_state;
						na_q <= next_action;
						iss_q <= '0;
						rv_q <= 1'b0;
						mfirst_q <= 1'b1;
						sub_q <= '0;
						pv_q <= 1'b0;
						mupd_q <= 1'b0;
						mxn_q <= '0;
						unique case (kind_t'(kind))
							KIND_STEP: state_q <= S_SCANN;
							KIND_END: state_q <= S_RDCUR;
							KIND_START: begin
								cur_s_q <= next_state;
								cur_a_q <= next_action;
								rep_s_q <= next_state;
								state_q <= S_RDCUR;
							end
							default: begin
								rep_s_q <= cur_s_q;
								state_q <= S_RDCUR;
							end
						endcase
					end
				end
				S_SCANN: begin
					if (scan_last) begin
						mxn_q <= (rdata_q > mx_q) ? rdata_q : mx_q;
						state_q <= S_RDCUR;
					end
				end
				S_RDCUR: begin
					// read current pair; data arrives next cycle
					state_q <= S_D1;
					sub_q <= '0;
					iss_q <= '0;
					rv_q <= 1'b0;
					mfirst_q <= 1'b1;
				end
				S_D1: begin
					if (kind_q == KIND_START || kind_q == KIND_NONE) begin
						upd_q <= rdata_q;
						state_q <= S_SCANR;
					end else begin
						upd_q <= rdata_q;
						d_q <= alu_y;
						sub_q <= sub_q + 1'b1;
						if (sub_q == 3'd2) begin
							state_q <= S_MUL1;
							pv_q <= 1'b0;
						end
					end
				end
				S_MUL1: begin
					prod_q <= $signed({1'b0, mrate}) * d_q;
					pv_q <= 1'b1;
					if (pv_q) begin
						upd_q <= alu_y;
						state_q <= S_WR;
					end
				end
				S_WR: state_q <= S_SCANC;
				S_SCANC: begin
					if (scan_last) begin
						sub_q <= '0;
						pv_q <= 1'b0;
						if (upd_q == ((rdata_q > mx_q) ? rdata_q : mx_q)) state_q <= S_MUL2;
						else state_q <= S_SCANR;
						if (kind_q == KIND_STEP) begin
							cur_s_q <= ns_q;
							cur_a_q <= na_q;
							rep_s_q <= ns_q;
						end else begin
							rep_s_q <= cur_s_q;
						end
					end
				end
				S_MUL2: begin
					// mean update: d = r - avg + mxn - mx, avg += rate*d/65536
					if (sub_q <= 3'd2) begin
						d_q <= alu_y;
						sub_q <= sub_q + 1'b1;
					end else if (sub_q == 3'd3) begin
						prod_q <= $signed({1'b0, mrate}) * d_q;
						sub_q <= sub_q + 1'b1;
					end else begin
						avg_q <= alu_y;
						mupd_q <= 1'b1;
						iss_q <= '0;
						rv_q <= 1'b0;
						mfirst_q <= 1'b1;
						state_q <= S_SCANR;
					end
				end
				S_SCANR: begin
					if (scan_last) begin
						greedy_value <= (rdata_q > mx_q) ? rdata_q : mx_q;
						greedy_action <= (rdata_q > mx_q) ? ra_q : marg_q;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					updated_value <= upd_q;
					mean_reward <= avg_q;
					mean_updated <= mupd_q;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`ARTD_ASSERT_IMP(a_done_idle, done, state_q == S_IDLE)
	`ARTD_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	`ARTD_ASSERT_IMP(a_wr_clear, mem_we, state_q == S_CLEAR || state_q == S_WR)
endmodule
`default_nettype wire
